[rtl/lru_page_replacement_top_macros.svh]
// assertion macros for the lru page replacement block
// uses clock i_clk and reset i_rst_n of the including module
`ifndef LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define LRU_PAGE_REPLACEMENT_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define LRP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lrp same-cycle check failed");
`define LRP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lrp next-cycle check failed");
`else
`define LRP_ASSERT_IMP(lbl, ante, cons)
`define LRP_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[rtl/lrp_pkg.sv]
// shared types and constants of the lru page replacement block
// no dependencies
`timescale 1ns / 1ps
package lrp_pkg;

    localparam int LRP_PAGE_W    = 16;
    localparam int LRP_SLOT_W    = 3;
    localparam int LRP_FAULT_W   = 32;
    localparam int LRP_CFG_W     = 4;
    localparam int LRP_IDX_MAXW  = 6;
    localparam int LRP_PAGE_MAXW = 32;

    localparam logic [LRP_CFG_W-1:0] LRP_CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    // search token passed down the row of frame cells
    typedef struct packed {
        logic [LRP_PAGE_MAXW-1:0] page;
        logic                     hit_found;
        logic [LRP_IDX_MAXW-1:0]  hit_idx;
        logic [LRP_IDX_MAXW-1:0]  hit_rank;
        logic                     empty_found;
        logic [LRP_IDX_MAXW-1:0]  empty_idx;
        logic                     lru_found;
        logic [LRP_IDX_MAXW-1:0]  lru_idx;
        logic [LRP_IDX_MAXW-1:0]  lru_rank;
        logic [LRP_PAGE_MAXW-1:0] lru_page;
    } t_tok;

    // commit broadcast to all cells
    typedef struct packed {
        logic                     en;
        logic                     miss;
        logic                     inc_all;
        logic [LRP_IDX_MAXW-1:0]  slot;
        logic [LRP_IDX_MAXW-1:0]  old_rank;
        logic [LRP_PAGE_MAXW-1:0] page;
    } t_upd;

endpackage

[rtl/lrp_ifs.sv]
// valid/ready stream interfaces for page reference words and result words
// depends on lrp_pkg
`timescale 1ns / 1ps
interface lrp_in_if import lrp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LRP_PAGE_W-1:0] page_number;

    modport source (output valid, output page_number, input ready);
    modport sink (input valid, input page_number, output ready);
endinterface

interface lrp_out_if import lrp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   hit;
    logic [LRP_SLOT_W-1:0]  frame_slot;
    logic                   used_empty_frame;
    logic                   evicted_valid;
    logic [LRP_PAGE_W-1:0]  evicted_page;
    logic [LRP_FAULT_W-1:0] fault_total;

    modport source (output valid, output hit, output frame_slot, output used_empty_frame,
                    output evicted_valid, output evicted_page, output fault_total,
                    input ready);
    modport sink (input valid, input hit, input frame_slot, input used_empty_frame,
                  input evicted_valid, input evicted_page, input fault_total,
                  output ready);
endinterface

[rtl/lrp_cell.sv]
// one page frame cell: holds page, valid and recency rank, refines the search token
// depends on lrp_pkg
`timescale 1ns / 1ps
module lrp_cell import lrp_pkg::*; #(
    parameter int INDEX     = 0,
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [LRP_CFG_W-1:0] i_frames_cfg,
    input  t_tok                 i_tok,
    input  t_upd                 i_upd,
    output t_tok                 o_tok
);

    localparam int RANK_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

    logic                 r_valid;
    logic [RANK_W-1:0]    r_rank;
    logic [PAGE_BITS-1:0] r_page;
    t_tok                 r_tok;
    t_tok                 n_tok;

    logic                    w_active;
    logic                    w_hit_here;
    logic [LRP_IDX_MAXW-1:0] w_rank_ext;
    logic [LRP_IDX_MAXW-1:0] w_index;
    logic                    w_sel;
    logic                    w_age;

    assign w_active   = (INDEX == 0) || (32'(i_frames_cfg) > INDEX);
    assign w_rank_ext = LRP_IDX_MAXW'(r_rank);
    assign w_index    = LRP_IDX_MAXW'(INDEX);
    assign w_hit_here = w_active && r_valid && (r_page == i_tok.page[PAGE_BITS-1:0]);
    assign w_sel      = i_upd.en && (i_upd.slot == w_index);
    assign w_age      = i_upd.en && !w_sel && r_valid &&
                        (i_upd.inc_all || (w_rank_ext < i_upd.old_rank));

    always_comb begin
        n_tok = i_tok;
        if (!i_tok.hit_found && w_hit_here) begin
            n_tok.hit_found = 1'b1;
            n_tok.hit_idx   = w_index;
            n_tok.hit_rank  = w_rank_ext;
        end
        if (!i_tok.empty_found && w_active && !r_valid) begin
            n_tok.empty_found = 1'b1;
            n_tok.empty_idx   = w_index;
        end
        if (w_active && r_valid && (!i_tok.lru_found || (w_rank_ext > i_tok.lru_rank))) begin
            n_tok.lru_found = 1'b1;
            n_tok.lru_idx   = w_index;
            n_tok.lru_rank  = w_rank_ext;
            n_tok.lru_page  = LRP_PAGE_MAXW'(r_page);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_sel) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
        if (w_sel) begin
            r_rank <= '0;
            if (i_upd.miss) begin
                r_page <= i_upd.page[PAGE_BITS-1:0];
            end
        end else if (w_age) begin
            r_rank <= r_rank + 1'b1;
        end
    end

    assign o_tok = r_tok;

endmodule

[rtl/lrp_ctrl.sv]
// sequencer: takes a reference word, runs the scan down the cell row, commits
// the decision and holds the result word; depends on lrp_pkg and lrp_ifs
`timescale 1ns / 1ps
module lrp_ctrl import lrp_pkg::*; #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LRP_CFG_W-1:0] i_cfg_wr_data,
    lrp_in_if.sink               i_in,
    lrp_out_if.source            o_out,
    input  t_tok                 i_tail_tok,
    output t_tok                 o_head_tok,
    output t_upd                 o_upd,
    output logic [LRP_CFG_W-1:0] o_frames_cfg
);

    localparam int CNT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAMES - 1);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [LRP_CFG_W-1:0] r_frames_cfg;
    logic [LRP_FAULT_W-1:0] r_fault;
    logic [LRP_FAULT_W-1:0] n_fault;
    logic [PAGE_BITS-1:0] r_page;
    logic                 r_out_valid;
    logic                 r_hit;
    logic [LRP_SLOT_W-1:0] r_slot;
    logic                 r_empty;
    logic                 r_evict;
    logic [LRP_PAGE_W-1:0] r_ev_page;

    logic                    w_in_ready;
    logic                    w_accept;
    logic                    w_scan_done;
    logic                    w_commit;
    logic [31:0]             w_page32;
    logic                    w_miss;
    logic                    w_empty;
    logic                    w_evict;
    logic [LRP_IDX_MAXW-1:0] w_slot;
    logic [LRP_IDX_MAXW-1:0] w_old_rank;

    assign w_page32 = {16'b0, i_in.page_number};
    assign w_accept = i_in.valid && w_in_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_done) n_state = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (w_commit) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_in_ready  = 1'b0;
        w_scan_done = 1'b0;
        w_commit    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_in_ready = 1'b1;
            end
            ST_SCAN: begin
                w_scan_done = (r_cnt == CNT_LAST);
            end
            ST_COMMIT: begin
                w_commit = !r_out_valid || o_out.ready;
            end
            default: begin
                w_in_ready = 1'b0;
            end
        endcase
    end

    // decision from the token leaving the last cell
    always_comb begin
        w_miss  = !i_tail_tok.hit_found;
        w_empty = w_miss && i_tail_tok.empty_found;
        w_evict = w_miss && !i_tail_tok.empty_found;
        priority if (i_tail_tok.hit_found) begin
            w_slot     = i_tail_tok.hit_idx;
            w_old_rank = i_tail_tok.hit_rank;
        end else if (i_tail_tok.empty_found) begin
            w_slot     = i_tail_tok.empty_idx;
            w_old_rank = i_tail_tok.lru_rank;
        end else begin
            w_slot     = i_tail_tok.lru_idx;
            w_old_rank = i_tail_tok.lru_rank;
        end
        n_fault = r_fault;
        if (w_miss && (r_fault != '1)) begin
            n_fault = r_fault + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_frames_cfg <= LRP_CFG_RESET;
            r_fault      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state != ST_SCAN) || w_scan_done) begin
                r_cnt <= '0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cfg_wr_en) begin
                r_frames_cfg <= i_cfg_wr_data;
            end
            if (w_commit) begin
                r_fault     <= n_fault;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= w_page32[PAGE_BITS-1:0];
        end
        if (w_commit) begin
            r_hit     <= i_tail_tok.hit_found;
            r_slot    <= w_slot[LRP_SLOT_W-1:0];
            r_empty   <= w_empty;
            r_evict   <= w_evict;
            r_ev_page <= w_evict ? i_tail_tok.lru_page[LRP_PAGE_W-1:0] : '0;
        end
    end

    always_comb begin
        o_head_tok      = '0;
        o_head_tok.page = LRP_PAGE_MAXW'(r_page);
    end

    always_comb begin
        o_upd          = '0;
        o_upd.en       = w_commit;
        o_upd.miss     = w_miss;
        o_upd.inc_all  = w_empty;
        o_upd.slot     = w_slot;
        o_upd.old_rank = w_old_rank;
        o_upd.page     = LRP_PAGE_MAXW'(r_page);
    end

    assign i_in.ready             = w_in_ready;
    assign o_out.valid            = r_out_valid;
    assign o_out.hit              = r_hit;
    assign o_out.frame_slot       = r_slot;
    assign o_out.used_empty_frame = r_empty;
    assign o_out.evicted_valid    = r_evict;
    assign o_out.evicted_page     = r_ev_page;
    assign o_out.fault_total      = r_fault;
    assign o_frames_cfg           = r_frames_cfg;

endmodule

[rtl/lru_page_replacement_top.sv]
// lru page replacement over a fully associative row of page frames
// usage:
//   i_in carries one page reference word; i_in.ready is high only while idle
//   o_out carries one result word per reference: hit, frame slot, empty fill,
//   eviction flag and page, and the saturating fault total
//   i_cfg_wr_en/i_cfg_wr_data write frames_in_use; write only while idle
// timing:
//   a reference travels down the cell row one frame cell per cycle, then one
//   commit cycle updates all cells and loads the output register
//   latency from accept to result valid: FRAMES + 1 cycles
//   a new word is accepted every FRAMES + 2 cycles (10 at eight frames)
// reset: all frames empty, fault total zero, frames_in_use 8
// stall: the next word is accepted and scanned while a result waits; its
//   commit holds until the waiting result is taken
// depends on lrp_pkg, lrp_ifs, lrp_cell, lrp_ctrl and the macros header
`timescale 1ns / 1ps
`include "lru_page_replacement_top_macros.svh"
module lru_page_replacement_top import lrp_pkg::*; #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [LRP_CFG_W-1:0] i_cfg_wr_data,
    lrp_in_if.sink               i_in,
    lrp_out_if.source            o_out
);

    t_tok                 w_tok [0:FRAMES];
    t_upd                 w_upd;
    logic [LRP_CFG_W-1:0] w_frames_cfg;

    lrp_ctrl #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in          (i_in),
        .o_out         (o_out),
        .i_tail_tok    (w_tok[FRAMES]),
        .o_head_tok    (w_tok[0]),
        .o_upd         (w_upd),
        .o_frames_cfg  (w_frames_cfg)
    );

    for (genvar g = 0; g < FRAMES; g++) begin : g_cell
        lrp_cell #(
            .INDEX     (g),
            .FRAMES    (FRAMES),
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_frames_cfg (w_frames_cfg),
            .i_tok        (w_tok[g]),
            .i_upd        (w_upd),
            .o_tok        (w_tok[g+1])
        );
    end

    `LRP_ASSERT_IMP(a_hit_excl, o_out.valid && o_out.hit, !o_out.evicted_valid && !o_out.used_empty_frame)
    `LRP_ASSERT_IMP(a_miss_kind, o_out.valid && !o_out.hit, o_out.evicted_valid ^ o_out.used_empty_frame)
    `LRP_ASSERT_NXT(a_commit_out, w_upd.en, o_out.valid)
    `LRP_ASSERT_NXT(a_miss_count, w_upd.en && w_upd.miss, o_out.fault_total != '0)

endmodule
